FILE: design/ils_pkg.sv
// ---------------------------------------------------------------------------
// ils_pkg: shared definitions for the indexed list store
// Field widths, request and status codes, and the engine command word.
// ---------------------------------------------------------------------------
`default_nettype none

package ils_pkg;

  localparam int CAPACITY_DEF = 256;

  localparam int REQ_W  = 3;
  localparam int POS_W  = 9;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;

  // request codes
  localparam logic [REQ_W-1:0] REQ_READ     = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_HEAD = 3'd1;
  localparam logic [REQ_W-1:0] REQ_INS_TAIL = 3'd2;
  localparam logic [REQ_W-1:0] REQ_INS_POS  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_DEL_POS  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

  localparam logic [DATA_W-1:0] RD_BAD = '1;

  // engine operations
  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } eng_op_t;

  typedef struct packed {
    logic    start;
    eng_op_t op;
  } eng_cmd_t;

endpackage

`default_nettype wire

FILE: design/ils_engine.sv
// ---------------------------------------------------------------------------
// ils_engine: entry memory and shift sequencer
// Reads one entry, or opens/closes a gap by moving entries one per cycle
// through a single incrementer/decrementer that steps the memory pointer.
// ---------------------------------------------------------------------------
`default_nettype none

module ils_engine #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF,
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire ils_pkg::eng_cmd_t         cmd,
  input  wire logic [CW-1:0]             at,
  input  wire logic [CW-1:0]             cnt,
  input  wire logic [ils_pkg::DATA_W-1:0] val,
  output logic                           done,
  output logic [ils_pkg::DATA_W-1:0]     rd_value
);

  import ils_pkg::*;

  localparam int AW = $clog2(CAPACITY);

  typedef enum logic [3:0] {
    E_IDLE   = 4'b0001,
    E_RDWAIT = 4'b0010,
    E_SHIFT  = 4'b0100,
    E_FILL   = 4'b1000
  } eng_state_t;

  eng_state_t state, state_next;

  logic [DATA_W-1:0] mem [CAPACITY];
  logic [DATA_W-1:0] rd_data;

  eng_op_t           op;
  logic [CW-1:0]     at_q, cnt_q, rd_ptr, wr_ptr;
  logic [DATA_W-1:0] val_q;
  logic              done_next;

  // shared pointer stepper
  logic [CW-1:0] step_in, step_out;
  logic          step_up;

  logic              we;
  logic [CW-1:0]     waddr, raddr;
  logic [DATA_W-1:0] wdata;

  assign step_out = step_up ? step_in + CW'(1) : step_in - CW'(1);

  always_comb begin
    state_next = state;
    done_next  = 1'b0;
    step_in    = rd_ptr;
    step_up    = (op == OP_CLOSE);
    raddr      = rd_ptr;
    we         = 1'b0;
    waddr      = wr_ptr;
    wdata      = rd_data;
    case (state)
      E_IDLE: begin
        step_in = (cmd.op == OP_CLOSE) ? at : cnt;
        step_up = (cmd.op == OP_CLOSE);
        if (cmd.start) begin
          case (cmd.op)
            OP_READ: begin
              raddr      = at;
              state_next = E_RDWAIT;
            end
            OP_OPEN: begin
              raddr = step_out;
              if (at == cnt) begin
                state_next = E_FILL;
              end else begin
                state_next = E_SHIFT;
              end
            end
            OP_CLOSE: begin
              raddr = step_out;
              if (step_out >= cnt) begin
                done_next = 1'b1;
              end else begin
                state_next = E_SHIFT;
              end
            end
            default: begin
              done_next = 1'b1;
            end
          endcase
        end
      end
      E_RDWAIT: begin
        done_next  = 1'b1;
        state_next = E_IDLE;
      end
      E_SHIFT: begin
        // move the entry just read one place along
        we    = 1'b1;
        raddr = step_out;
        if (op == OP_OPEN) begin
          if (rd_ptr == at_q) begin
            state_next = E_FILL;
          end
        end else begin
          if (step_out == cnt_q) begin
            done_next  = 1'b1;
            state_next = E_IDLE;
          end
        end
      end
      E_FILL: begin
        we         = 1'b1;
        waddr      = at_q;
        wdata      = val_q;
        done_next  = 1'b1;
        state_next = E_IDLE;
      end
      default: begin
        state_next = E_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == E_IDLE && cmd.start) begin
      op     <= cmd.op;
      at_q   <= at;
      cnt_q  <= cnt;
      val_q  <= val;
      rd_ptr <= step_out;
      wr_ptr <= (cmd.op == OP_CLOSE) ? at : cnt;
    end else if (state == E_SHIFT) begin
      rd_ptr <= step_out;
      wr_ptr <= rd_ptr;
    end
    if (state == E_RDWAIT) begin
      rd_value <= rd_data;
    end
  end

  // entry memory: one write, one registered read per cycle
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr[AW-1:0]] <= wdata;
    end
    rd_data <= mem[raddr[AW-1:0]];
  end

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.start |-> state == E_IDLE)
    else $error("engine started while busy");

  a_waddr_range: assert property (@(posedge clk) disable iff (rst)
    we |-> waddr < CW'(CAPACITY))
    else $error("write beyond capacity");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> state == E_IDLE)
    else $error("done raised with work still running");

endmodule

`default_nettype wire

FILE: design/indexed_list_store.sv
// ---------------------------------------------------------------------------
// indexed_list_store: ordered list of signed words held in one memory
// Reads by position, inserts at head, tail or position, deletes by position;
// later entries are shifted one place per cycle by the list engine.
// ---------------------------------------------------------------------------
//
//   channel  handshake           words carried
//   -------  ------------------  ---------------------------------------
//   in       in_valid/in_stall   req_type, position, value
//   out      out_valid/out_stall read_value, status, entry_count
//
// A read passes through the launch, run and push states before its result
// word is presented. An insert or delete moves every later entry one place:
// the engine moves one entry per cycle through its single memory port
// pair. Refused requests and unused codes skip the engine and go straight
// to the push state.
// Reset clears the entry count, state and output valid; the memory needs no clearing pass.
// in_stall is high from acceptance until the result is loaded into the
// output register; a stalled result holds there while the next word enters.
// ---------------------------------------------------------------------------
`default_nettype none

module indexed_list_store #(
  parameter int CAPACITY = ils_pkg::CAPACITY_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             in_valid,
  output logic                                  in_stall,
  input  wire logic [ils_pkg::REQ_W-1:0]         req_type,
  input  wire logic [ils_pkg::POS_W-1:0]         position,
  input  wire logic signed [ils_pkg::DATA_W-1:0] value,
  output logic                                  out_valid,
  input  wire logic                             out_stall,
  output logic signed [ils_pkg::DATA_W-1:0]      read_value,
  output logic [ils_pkg::STAT_W-1:0]             status,
  output logic [ils_pkg::POS_W-1:0]              entry_count
);

  import ils_pkg::*;

  localparam int CW   = $clog2(CAPACITY + 1);
  localparam int CMPW = (CW > POS_W) ? CW : POS_W;

  typedef enum logic [3:0] {
    T_IDLE   = 4'b0001,
    T_LAUNCH = 4'b0010,
    T_RUN    = 4'b0100,
    T_PUSH   = 4'b1000
  } top_state_t;

  top_state_t state;

  logic [CW-1:0] count;

  // latched engine command
  eng_op_t           op_q;
  logic [CW-1:0]     at_q, cnt_q;
  logic [DATA_W-1:0] val_q;
  eng_cmd_t          cmd;
  logic              eng_done;
  logic [DATA_W-1:0] eng_rdata;

  // pending result word
  logic [DATA_W-1:0] res_rv;
  logic [STAT_W-1:0] res_st;
  logic [POS_W-1:0]  res_cnt;

  // request decode
  logic              in_fire, full, need_eng;
  logic [CMPW-1:0]   pos_c, cnt_c, cnt_next_c;
  eng_op_t           dec_op;
  logic [CW-1:0]     dec_at, count_next;
  logic [DATA_W-1:0] imm_rv;
  logic [STAT_W-1:0] imm_st;
  logic              push;

  assign in_fire  = in_valid && !in_stall;
  assign in_stall = (state != T_IDLE);
  assign full     = (count == CW'(CAPACITY));
  assign pos_c    = CMPW'(position);
  assign cnt_c    = CMPW'(count);

  always_comb begin
    need_eng   = 1'b0;
    dec_op     = OP_READ;
    dec_at     = pos_c[CW-1:0];
    imm_rv     = '0;
    imm_st     = ST_DONE;
    count_next = count;
    case (req_type)
      REQ_READ: begin
        if (pos_c < cnt_c) begin
          need_eng = 1'b1;
        end else begin
          imm_rv = RD_BAD;
          imm_st = ST_RANGE;
        end
      end
      REQ_INS_HEAD, REQ_INS_TAIL: begin
        if (full) begin
          imm_st = ST_FULL;
        end else begin
          need_eng   = 1'b1;
          dec_op     = OP_OPEN;
          dec_at     = (req_type == REQ_INS_HEAD) ? '0 : count;
          count_next = count + CW'(1);
        end
      end
      REQ_INS_POS: begin
        // range check takes precedence over the full check
        if (pos_c > cnt_c) begin
          imm_st = ST_RANGE;
        end else if (full) begin
          imm_st = ST_FULL;
        end else begin
          need_eng   = 1'b1;
          dec_op     = OP_OPEN;
          count_next = count + CW'(1);
        end
      end
      REQ_DEL_POS: begin
        if (pos_c < cnt_c) begin
          need_eng   = 1'b1;
          dec_op     = OP_CLOSE;
          count_next = count - CW'(1);
        end else begin
          imm_st = ST_RANGE;
        end
      end
      default: begin
        // unused codes: no change, plain done
      end
    endcase
  end

  assign cnt_next_c = CMPW'(count_next);
  assign push       = (state == T_PUSH) && !(out_valid && out_stall);

  assign cmd.start = (state == T_LAUNCH);
  assign cmd.op    = op_q;

  ils_engine #(
    .CAPACITY (CAPACITY)
  ) u_engine (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .at       (at_q),
    .cnt      (cnt_q),
    .val      (val_q),
    .done     (eng_done),
    .rd_value (eng_rdata)
  );

  // control: sequencer state, entry count, output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= T_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      case (state)
        T_IDLE: begin
          if (in_fire) begin
            count <= count_next;
            state <= need_eng ? T_LAUNCH : T_PUSH;
          end
        end
        T_LAUNCH: begin
          state <= T_RUN;
        end
        T_RUN: begin
          if (eng_done) begin
            state <= T_PUSH;
          end
        end
        T_PUSH: begin
          if (push) begin
            state <= T_IDLE;
          end
        end
        default: begin
          state <= T_IDLE;
        end
      endcase
      // hold the word while stalled, drop it once taken
      if (push) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload: command latch, pending result, output register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q    <= dec_op;
      at_q    <= dec_at;
      cnt_q   <= count;
      val_q   <= value;
      res_rv  <= imm_rv;
      res_st  <= imm_st;
      res_cnt <= cnt_next_c[POS_W-1:0];
    end else if (state == T_RUN && eng_done && op_q == OP_READ) begin
      res_rv <= eng_rdata;
    end
    if (push) begin
      read_value  <= res_rv;
      status      <= res_st;
      entry_count <= res_cnt;
    end
  end

  a_count_cap: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    eng_done |-> state == T_RUN)
    else $error("engine finished outside the run phase");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    !in_fire |=> $stable(count))
    else $error("entry count moved without a request");

  a_push_loads: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid && state == T_IDLE)
    else $error("result word not presented after push");

endmodule

`default_nettype wire
